// ----- hdl/assert_macros.svh -----
// Assertion macros for the RTL; included by the tagger top level.
// Each macro checks on the rising edge of clk and is disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("assertion failed: same-cycle implication");

// Condition must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- hdl/edm_pkg.sv -----
// Package for the edit-distance / MD-tag tagger: payload types and codes.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package edm_pkg;

  localparam logic [1:0] CMD_PAIR     = 2'd0;
  localparam logic [1:0] CMD_GAP      = 2'd1;
  localparam logic [1:0] CMD_DEL_BASE = 2'd2;
  localparam logic [1:0] CMD_END      = 2'd3;

  localparam logic [1:0] KIND_MISMATCH  = 2'd0;
  localparam logic [1:0] KIND_DEL_START = 2'd1;
  localparam logic [1:0] KIND_DEL_BASE  = 2'd2;
  localparam logic [1:0] KIND_FINAL     = 2'd3;

  localparam logic [2:0] BASE_N = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  read_base;
    logic [2:0]  ref_base;
    logic [31:0] gap_ref_len;
    logic [15:0] gap_read_len;
    logic        gap_is_indel;
    logic        gap_is_deletion;
  } edm_in_t;

  typedef struct packed {
    logic [1:0]  token_kind;
    logic [15:0] run_length;
    logic [2:0]  base_code;
    logic [31:0] edit_distance;
    logic        last;
  } edm_out_t;

  typedef struct packed {
    logic    valid;
    edm_in_t data;
  } edm_stage_t;

  typedef struct packed {
    logic     valid;
    edm_out_t data;
  } edm_res_t;

endpackage

`default_nettype wire

// ----- hdl/edm_in_reg.sv -----
// Input register of the tagger: holds one accepted word until the core takes it.
// Depends on edm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module edm_in_reg
  import edm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire edm_in_t    item,
  input  wire logic       adv,
  output edm_stage_t      stage
);

  logic    valid;
  edm_in_t data;
  logic    load;

  assign load       = !valid || adv;
  assign item_stall = !load;
  assign stage      = '{valid: valid, data: data};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && item_valid) begin
      data <= item;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/edm_core.sv -----
// Tagger core: run and edit-total counters and the token decision for one word.
// Depends on edm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module edm_core
  import edm_pkg::*;
#(
  parameter int RUN_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire edm_stage_t stage,
  input  wire logic       out_free,
  output logic            adv,
  output edm_res_t        res
);

  logic [RUN_BITS-1:0]    match_run;
  logic [RUN_BITS-1:0]    match_run_next;
  logic [31:0]            edit_total;
  logic [31:0]            edit_total_next;
  logic [RUN_BITS+15:0]   run_wide;
  logic [15:0]            run_out;
  logic                   mismatch;
  logic [33:0]            gap_sum;
  logic [31:0]            gap_total;
  logic [31:0]            inc_total;
  logic [RUN_BITS-1:0]    inc_run;
  edm_in_t                d;

  assign d        = stage.data;
  assign run_wide = {16'd0, match_run};
  assign run_out  = run_wide[15:0];
  assign mismatch = (d.read_base != d.ref_base) || (d.read_base >= BASE_N)
                    || (d.ref_base >= BASE_N);
  assign gap_sum  = {2'b00, edit_total} + {18'd0, d.gap_read_len}
                    + (d.gap_is_indel ? {2'b00, d.gap_ref_len} : 34'd0);
  assign gap_total = (gap_sum[33:32] != 2'b00) ? '1 : gap_sum[31:0];
  assign inc_total = (edit_total == '1) ? edit_total : edit_total + 32'd1;
  assign inc_run   = (match_run == '1) ? match_run : match_run + RUN_BITS'(1);

  always_comb begin
    match_run_next  = match_run;
    edit_total_next = edit_total;
    res.valid       = 1'b0;
    res.data        = '0;
    case (d.cmd)
      CMD_PAIR: begin
        if (mismatch) begin
          edit_total_next          = inc_total;
          match_run_next           = '0;
          res.valid                = 1'b1;
          res.data.token_kind      = KIND_MISMATCH;
          res.data.run_length      = run_out;
          res.data.base_code       = d.ref_base;
        end else begin
          match_run_next = inc_run;
        end
      end
      CMD_GAP: begin
        edit_total_next = gap_total;
        if (d.gap_is_deletion) begin
          match_run_next      = '0;
          res.valid           = 1'b1;
          res.data.token_kind = KIND_DEL_START;
          res.data.run_length = run_out;
        end
      end
      CMD_DEL_BASE: begin
        res.valid           = 1'b1;
        res.data.token_kind = KIND_DEL_BASE;
        res.data.base_code  = d.ref_base;
      end
      default: begin
        match_run_next         = '0;
        edit_total_next        = '0;
        res.valid              = 1'b1;
        res.data.token_kind    = KIND_FINAL;
        res.data.run_length    = run_out;
        res.data.edit_distance = edit_total;
        res.data.last          = 1'b1;
      end
    endcase
    res.valid = res.valid && stage.valid;
  end

  assign adv = stage.valid && (out_free || !res.valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      match_run  <= '0;
      edit_total <= '0;
    end else if (adv) begin
      match_run  <= match_run_next;
      edit_total <= edit_total_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/edm_out_reg.sv -----
// Output register of the tagger: holds one token until the consumer takes it.
// Depends on edm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module edm_out_reg
  import edm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire edm_res_t res,
  output logic          out_free,
  output logic          token_valid,
  input  wire logic     token_stall,
  output edm_out_t      token
);

  assign out_free = !token_valid || !token_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
    end else if (out_free) begin
      token_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      token <= res.data;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/edit_distance_md_tagger.sv -----
// Edit-distance / MD-tag tagger top level; uses edm_pkg, edm_in_reg, edm_core, edm_out_reg.
// An accepted word passes through the input register and the output register to its token.
// One word per cycle while token_stall is low; the counter update is combinational.
// Words that cause no token leave the pipe without occupying the output register.
// Reset (rst, synchronous): clears both valid flags, the match run and the edit total.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module edit_distance_md_tagger
  import edm_pkg::*;
#(
  parameter int RUN_BITS = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_stall,
  input  wire edm_in_t item,
  output logic         token_valid,
  input  wire logic    token_stall,
  output edm_out_t     token
);

  edm_stage_t stage;
  edm_res_t   res;
  logic       adv;
  logic       out_free;

  edm_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .adv        (adv),
    .stage      (stage)
  );

  edm_core #(
    .RUN_BITS (RUN_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .stage    (stage),
    .out_free (out_free),
    .adv      (adv),
    .res      (res)
  );

  edm_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .res         (res),
    .out_free    (out_free),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token       (token)
  );

  `ASSERT_SAME(a_stall_needs_full_out, item_stall, token_valid && token_stall)
  `ASSERT_SAME(a_last_on_final, token_valid, token.last == (token.token_kind == KIND_FINAL))
  `ASSERT_SAME(a_del_base_clean, token_valid && (token.token_kind == KIND_DEL_BASE),
    (token.run_length == 16'd0) && (token.edit_distance == 32'd0))
  `ASSERT_NEXT(a_stall_holds_out, token_valid && token_stall, token_valid && $stable(token))

endmodule

`default_nettype wire
